// File: rtl/core/tangent_crossing_test_macros.svh
// assertion macros shared by the tangent crossing test files
`ifndef TANGENT_CROSSING_TEST_MACROS_SVH
`define TANGENT_CROSSING_TEST_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tct assertion failed");

// next-cycle implication, disabled during reset
`define TCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tct assertion failed");

`endif

// File: rtl/core/tct_pkg.sv
// types, constants and helper functions of the tangent crossing test
package tct_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int COORD_W       = 32;
  localparam int XW            = 36;
  localparam int TURN_W        = 32;
  localparam int TOL_W         = 10;
  localparam int IDX_W         = 5;
  localparam int NUM_LANES     = 4;
  localparam int CMP_W         = ((ANGLE_BITS > TOL_W) ? ANGLE_BITS : TOL_W) + 1;
  localparam int ROUND_SHIFT   = TURN_W - ANGLE_BITS;

  localparam int LANE_A0 = 0;
  localparam int LANE_A1 = 1;
  localparam int LANE_B0 = 2;
  localparam int LANE_B1 = 3;

  localparam logic [TURN_W-1:0] TURN_ZERO    = 32'h0000_0000;
  localparam logic [TURN_W-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [TURN_W-1:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [TURN_W-1:0] TURN_3Q      = 32'hC000_0000;

  localparam logic [TURN_W:0] ROUND_HALF = (33'd1 << ROUND_SHIFT) >> 1;

  // atan(2^-i) in turns scaled by 2^32
  localparam logic [TURN_W-1:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef point_t [NUM_LANES-1:0] points_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [TURN_W-1:0]    z;
    logic                 exact;
  } vec_t;

  typedef vec_t [NUM_LANES-1:0] lanes_t;

  typedef logic [ANGLE_BITS-1:0] angle_t;
  typedef angle_t [NUM_LANES-1:0] angles_t;

  function automatic angle_t round_angle(input logic [TURN_W-1:0] z);
    logic [TURN_W:0] s;
    s = {1'b0, z} + ROUND_HALF;
    return s[TURN_W-1 -: ANGLE_BITS];
  endfunction

  function automatic logic inside_arc(input angle_t lo, input angle_t hi, input angle_t t,
                                      input logic [TOL_W-1:0] tol);
    logic [CMP_W-1:0] lo_e;
    logic [CMP_W-1:0] hi_e;
    logic [CMP_W-1:0] t_e;
    logic [CMP_W-1:0] tol_e;
    logic             above;
    logic             below;
    lo_e  = CMP_W'(lo);
    hi_e  = CMP_W'(hi);
    t_e   = CMP_W'(t);
    tol_e = CMP_W'(tol);
    above = t_e > (lo_e + tol_e);
    below = (t_e + tol_e) < hi_e;
    return (lo <= hi) ? (above && below) : (above || below);
  endfunction

endpackage

// File: rtl/core/tct_prerot.sv
// input stage: axis cases, half-turn pre-rotation and widening of the four vectors
module tct_prerot import tct_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  points_t in_points,
  output logic    out_valid,
  input  logic    out_ready,
  output lanes_t  out_data
);

  `include "tangent_crossing_test_macros.svh"

  logic   valid_r;
  lanes_t data_r;
  lanes_t data_nxt;

  always_comb begin
    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] ye;
    for (int l = 0; l < NUM_LANES; l++) begin
      xe = XW'(in_points[l].x);
      ye = XW'(in_points[l].y);
      data_nxt[l].x     = xe;
      data_nxt[l].y     = ye;
      data_nxt[l].z     = TURN_ZERO;
      data_nxt[l].exact = 1'b0;
      if (in_points[l].y == '0) begin
        data_nxt[l].z     = (in_points[l].x < 0) ? TURN_HALF : TURN_ZERO;
        data_nxt[l].exact = 1'b1;
      end else if (in_points[l].x == '0) begin
        data_nxt[l].z     = (in_points[l].y > 0) ? TURN_QUARTER : TURN_3Q;
        data_nxt[l].exact = 1'b1;
      end else if (in_points[l].x < 0) begin
        data_nxt[l].x = -xe;
        data_nxt[l].y = -ye;
        data_nxt[l].z = TURN_HALF;
      end
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  // exact lanes sit on a quarter-turn boundary; checked here on lane A0
  `TCT_ASSERT_NOW(exact_on_axis, valid_r && data_r[LANE_A0].exact,
                  data_r[LANE_A0].z[TURN_W-3:0] == '0)

endmodule

// File: rtl/core/tct_cordic_stage.sv
// one vectoring step of the cordic for all four lanes, registered
module tct_cordic_stage import tct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] stage_idx,
  input  logic             in_valid,
  output logic             in_ready,
  input  lanes_t           in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lanes_t           out_data
);

  `include "tangent_crossing_test_macros.svh"

  logic   valid_r;
  lanes_t data_r;
  lanes_t data_nxt;

  always_comb begin
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    for (int l = 0; l < NUM_LANES; l++) begin
      data_nxt[l] = in_data[l];
      dx = in_data[l].y >>> stage_idx;
      dy = in_data[l].x >>> stage_idx;
      if (!in_data[l].exact) begin
        if (in_data[l].y < 0) begin
          data_nxt[l].x = in_data[l].x - dx;
          data_nxt[l].y = in_data[l].y + dy;
          data_nxt[l].z = in_data[l].z - ATAN_TAB[stage_idx];
        end else begin
          data_nxt[l].x = in_data[l].x + dx;
          data_nxt[l].y = in_data[l].y - dy;
          data_nxt[l].z = in_data[l].z + ATAN_TAB[stage_idx];
        end
      end
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  // a stalled stage keeps its word
  `TCT_ASSERT_NEXT(stage_hold, valid_r && !out_ready, valid_r && $stable(data_r))

endmodule

// File: rtl/core/tct_arc_test.sv
// angle rounding stage and arc membership stage producing the crossing flag
module tct_arc_test import tct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TOL_W-1:0] tol,
  input  logic             in_valid,
  output logic             in_ready,
  input  lanes_t           in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_cross
);

  logic    ang_valid_r;
  angles_t ang_r;
  angles_t ang_nxt;
  logic    ang_ready;
  logic    flag_valid_r;
  logic    flag_r;
  logic    flag_nxt;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      ang_nxt[l] = round_angle(in_data[l].z);
    end
  end

  always_comb begin
    logic in_a0;
    logic in_a1;
    logic in_b0;
    logic in_b1;
    in_a0 = inside_arc(ang_r[LANE_A0], ang_r[LANE_A1], ang_r[LANE_B0], tol);
    in_a1 = inside_arc(ang_r[LANE_A0], ang_r[LANE_A1], ang_r[LANE_B1], tol);
    in_b0 = inside_arc(ang_r[LANE_A1], ang_r[LANE_A0], ang_r[LANE_B0], tol);
    in_b1 = inside_arc(ang_r[LANE_A1], ang_r[LANE_A0], ang_r[LANE_B1], tol);
    flag_nxt = (in_a0 ^ in_a1) && (in_b0 ^ in_b1);
  end

  assign ang_ready = !flag_valid_r || out_ready;
  assign in_ready  = !ang_valid_r || ang_ready;
  assign out_valid = flag_valid_r;
  assign out_cross = flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_valid_r  <= 1'b0;
      flag_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        ang_valid_r <= in_valid;
      end
      if (ang_ready) begin
        flag_valid_r <= ang_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ang_r <= ang_nxt;
    end
    if (ang_ready && ang_valid_r) begin
      flag_r <= flag_nxt;
    end
  end

endmodule

// File: rtl/core/tangent_crossing_test.sv
// top level of the tangent crossing test: register, pipeline chain and ports
// path from input word to result word: pre-rotation register, cordic stage registers, angle register, flag register
// throughput: one word per cycle while out_ready is held high, set by the fully pipelined cordic lanes
// every stage holds its word under back pressure; bubbles are filled while stalled
// reset: synchronous active-low rst_n clears all valid bits and the tolerance to 0
// no clearing pass; ready for input in the first cycle after reset
module tangent_crossing_test import tct_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_edge_one_first_x,
  input  logic signed [31:0] in_edge_one_first_y,
  input  logic signed [31:0] in_edge_one_second_x,
  input  logic signed [31:0] in_edge_one_second_y,
  input  logic signed [31:0] in_edge_two_first_x,
  input  logic signed [31:0] in_edge_two_first_y,
  input  logic signed [31:0] in_edge_two_second_x,
  input  logic signed [31:0] in_edge_two_second_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_tangents_cross,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TOL_W-1:0]   cfg_data
);

  `include "tangent_crossing_test_macros.svh"

  logic [TOL_W-1:0] tol_r;
  points_t          points;
  lanes_t           stage_data  [CORDIC_STAGES+1];
  logic             stage_valid [CORDIC_STAGES+1];
  logic             stage_ready [CORDIC_STAGES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  assign points[LANE_A0] = '{x: in_edge_one_first_x,  y: in_edge_one_first_y};
  assign points[LANE_A1] = '{x: in_edge_one_second_x, y: in_edge_one_second_y};
  assign points[LANE_B0] = '{x: in_edge_two_first_x,  y: in_edge_two_first_y};
  assign points[LANE_B1] = '{x: in_edge_two_second_x, y: in_edge_two_second_y};

  tct_prerot u_prerot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_points (points),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_data  (stage_data[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    tct_cordic_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (IDX_W'(g)),
      .in_valid  (stage_valid[g]),
      .in_ready  (stage_ready[g]),
      .in_data   (stage_data[g]),
      .out_valid (stage_valid[g+1]),
      .out_ready (stage_ready[g+1]),
      .out_data  (stage_data[g+1])
    );
  end

  tct_arc_test u_arc_test (
    .clk       (clk),
    .rst_n     (rst_n),
    .tol       (tol_r),
    .in_valid  (stage_valid[CORDIC_STAGES]),
    .in_ready  (stage_ready[CORDIC_STAGES]),
    .in_data   (stage_data[CORDIC_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_cross (out_tangents_cross)
  );

  // an empty output stage means the whole chain can take a word
  `TCT_ASSERT_NOW(ready_when_drained, !out_valid, in_ready)
  // tolerance follows the last configuration word
  `TCT_ASSERT_NEXT(tol_written, cfg_valid && cfg_ready, tol_r == $past(cfg_data))

endmodule

// File: dv/tangent_crossing_checker.sv
// checker for the tangent crossing test: predicts each crossing flag and compares results
`timescale 1ns / 1ps

module tangent_crossing_checker import tct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  coord_t           in_edge_one_first_x,
  input  coord_t           in_edge_one_first_y,
  input  coord_t           in_edge_one_second_x,
  input  coord_t           in_edge_one_second_y,
  input  coord_t           in_edge_two_first_x,
  input  coord_t           in_edge_two_first_y,
  input  coord_t           in_edge_two_second_x,
  input  coord_t           in_edge_two_second_y,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_tangents_cross,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [TOL_W-1:0] cfg_data,
  output int               miscompares,
  output int               pending,
  output int               words_checked,
  output int               crossings_seen
);

  localparam int STAGES = CORDIC_STAGES;

  logic [TOL_W-1:0] tolerance;
  logic             crossing_due [$];
  logic             want;

  function automatic logic [31:0] arc_turn(input int k);
    case (k)
      0:  return 32'd536870912;
      1:  return 32'd316933406;
      2:  return 32'd167458907;
      3:  return 32'd85004756;
      4:  return 32'd42667331;
      5:  return 32'd21354465;
      6:  return 32'd10679838;
      7:  return 32'd5340245;
      8:  return 32'd2670163;
      9:  return 32'd1335087;
      10: return 32'd667544;
      11: return 32'd333772;
      12: return 32'd166886;
      13: return 32'd83443;
      14: return 32'd41722;
      15: return 32'd20861;
      16: return 32'd10430;
      17: return 32'd5215;
      18: return 32'd2608;
      19: return 32'd1304;
      20: return 32'd652;
      21: return 32'd326;
      22: return 32'd163;
      23: return 32'd81;
      24: return 32'd41;
      25: return 32'd20;
      26: return 32'd10;
      27: return 32'd5;
      28: return 32'd3;
      29: return 32'd1;
      30: return 32'd1;
      default: return 32'd0;
    endcase
  endfunction

  // polar angle of one tangent as a 16-bit turn fraction
  function automatic logic [15:0] turn_of(input coord_t xr, input coord_t yr);
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    logic [31:0] z;
    int          i;
    int          k;
    x = xr;
    y = yr;
    z = 32'h0;
    if (y == 0) begin
      z = (x < 0) ? 32'h8000_0000 : 32'h0;
    end else if (x == 0) begin
      z = (y > 0) ? 32'h4000_0000 : 32'hC000_0000;
    end else begin
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (i = 0; i < STAGES; i++) begin
        k = i & 31;
        dx = y >>> k;
        dy = x >>> k;
        if (y < 0) begin
          x = x - dx;
          y = y + dy;
          z = z - arc_turn(k);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + arc_turn(k);
        end
      end
    end
    z = z + 32'h0000_8000;
    return z[31:16];
  endfunction

  function automatic bit strictly_within(input int lo, input int hi, input int t, input int tol);
    bit above;
    bit below;
    above = t > lo + tol;
    below = t + tol < hi;
    return (lo <= hi) ? (above && below) : (above || below);
  endfunction

  function automatic logic tangents_cross_of(input int tol);
    int a0;
    int a1;
    int b0;
    int b1;
    int in_a;
    int in_b;
    a0 = turn_of(in_edge_one_first_x, in_edge_one_first_y);
    a1 = turn_of(in_edge_one_second_x, in_edge_one_second_y);
    b0 = turn_of(in_edge_two_first_x, in_edge_two_first_y);
    b1 = turn_of(in_edge_two_second_x, in_edge_two_second_y);
    in_a = strictly_within(a0, a1, b0, tol) + strictly_within(a0, a1, b1, tol);
    in_b = strictly_within(a1, a0, b0, tol) + strictly_within(a1, a0, b1, tol);
    return (in_a == 1 && in_b == 1);
  endfunction

  initial begin
    miscompares = 0;
    pending = 0;
    words_checked = 0;
    crossings_seen = 0;
    tolerance = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      tolerance = '0;
      crossing_due.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tolerance = cfg_data;
      end
      if (in_valid && in_ready) begin
        crossing_due.push_back(tangents_cross_of(int'(tolerance)));
      end
      if (out_valid && out_ready) begin
        if (crossing_due.size() == 0) begin
          miscompares++;
          if (miscompares <= 10) begin
            $display("unexpected result word, nothing due: got tangents_cross=%0b",
                     out_tangents_cross);
          end
        end else begin
          want = crossing_due.pop_front();
          words_checked++;
          if (want) crossings_seen++;
          if (out_tangents_cross !== want) begin
            miscompares++;
            if (miscompares <= 10) begin
              $display("tangents_cross mismatch on word %0d: expected %0b, got %0b",
                       words_checked, want, out_tangents_cross);
            end
          end
        end
      end
      pending <= crossing_due.size();
    end
  end

endmodule

// File: dv/testbench.sv
// top of the tangent crossing test bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import tct_pkg::*;

  typedef coord_t [7:0] word_t;

  localparam coord_t C_MAX = 32'sh7FFF_FFFF;
  localparam coord_t C_MIN = 32'sh8000_0000;
  localparam coord_t C_BIG = 32'sh4000_0000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  coord_t           drive_c [8];
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_tangents_cross;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TOL_W-1:0] cfg_data = '0;

  int miscompares;
  int pending;
  int words_checked;
  int crossings_seen;
  int send_idle = 19;
  int recv_idle = 63;
  int settings_used = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tangent_crossing_test DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_edge_one_first_x  (drive_c[0]),
    .in_edge_one_first_y  (drive_c[1]),
    .in_edge_one_second_x (drive_c[2]),
    .in_edge_one_second_y (drive_c[3]),
    .in_edge_two_first_x  (drive_c[4]),
    .in_edge_two_first_y  (drive_c[5]),
    .in_edge_two_second_x (drive_c[6]),
    .in_edge_two_second_y (drive_c[7]),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_tangents_cross   (out_tangents_cross),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data)
  );

  tangent_crossing_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_edge_one_first_x  (drive_c[0]),
    .in_edge_one_first_y  (drive_c[1]),
    .in_edge_one_second_x (drive_c[2]),
    .in_edge_one_second_y (drive_c[3]),
    .in_edge_two_first_x  (drive_c[4]),
    .in_edge_two_first_y  (drive_c[5]),
    .in_edge_two_second_x (drive_c[6]),
    .in_edge_two_second_y (drive_c[7]),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_tangents_cross   (out_tangents_cross),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .miscompares          (miscompares),
    .pending              (pending),
    .words_checked        (words_checked),
    .crossings_seen       (crossings_seen)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic word_t make(input coord_t x0, input coord_t y0, input coord_t x1,
                                 input coord_t y1, input coord_t x2, input coord_t y2,
                                 input coord_t x3, input coord_t y3);
    word_t w;
    w[0] = x0; w[1] = y0; w[2] = x1; w[3] = y1;
    w[4] = x2; w[5] = y2; w[6] = x3; w[7] = y3;
    return w;
  endfunction

  // tangent pointing at a given 16-bit turn fraction, random length
  function automatic logic [63:0] vector_at(input int units);
    real    r;
    real    phi;
    coord_t x;
    coord_t y;
    r = (2.0 ** $urandom_range(3, 29)) * (1.0 + $urandom_range(0, 999) / 1000.0);
    phi = 6.283185307179586 * (units & 65535) / 65536.0;
    x = $rtoi(r * $cos(phi));
    y = $rtoi(r * $sin(phi));
    return {x, y};
  endfunction

  function automatic coord_t odd_coord();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return C_MIN;
      2: return C_MAX;
      3: return $urandom_range(0, 16) - 8;
      4: return -1;
      5: return 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t random_word();
    word_t       w;
    logic [63:0] pt;
    int          kind;
    int          a0;
    int          a1;
    int          span_a;
    int          pick;
    int          src;
    int          i;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      a0 = $urandom_range(0, 65535);
      case ($urandom_range(0, 9))
        0: a1 = a0;
        1: a1 = a0 + 32768;
        2: a1 = a0 + $urandom_range(0, 3000) - 1500;
        default: a1 = $urandom_range(0, 65535);
      endcase
      a1 = a1 & 65535;
      pt = vector_at(a0);
      w[0] = pt[63:32]; w[1] = pt[31:0];
      pt = vector_at(a1);
      w[2] = pt[63:32]; w[3] = pt[31:0];
      span_a = (a1 - a0) & 65535;
      for (i = 4; i < 8; i += 2) begin
        src = $urandom_range(0, 5);
        if (src == 5) begin
          // exact copy of one endpoint tangent
          pick = 2 * $urandom_range(0, 1);
          w[i] = w[pick];
          w[i+1] = w[pick+1];
        end else begin
          case (src)
            0: pick = $urandom_range(0, 65535);
            1: pick = a0 + $urandom_range(0, 3000) - 1500;
            2: pick = a1 + $urandom_range(0, 3000) - 1500;
            3: pick = a0 + $urandom_range(0, span_a);
            default: pick = a1 + $urandom_range(0, 65535 - span_a);
          endcase
          pt = vector_at(pick);
          w[i] = pt[63:32];
          w[i+1] = pt[31:0];
        end
      end
    end else if (kind < 85) begin
      for (i = 0; i < 8; i++) w[i] = odd_coord();
    end else begin
      for (i = 0; i < 8; i++) w[i] = $urandom;
    end
    return w;
  endfunction

  function automatic word_t directed_word(input int n);
    case (n)
      0:  return make(0, 0, 0, 0, 0, 0, 0, 0);
      1:  return make(1, 0, -1, 0, 0, 1, 0, -1);
      2:  return make(0, 1, 0, -1, 1, 0, -1, 0);
      3:  return make(C_MAX, 0, C_MAX, 0, 0, 1, 0, -1);
      4:  return make(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN);
      5:  return make(C_MIN, 0, 0, C_MIN, C_MAX, 0, 0, C_MAX);
      6:  return make(C_MAX, -1, C_MAX, 1, 0, 1, 0, -1);
      7:  return make(1, 1, -1, -1, -1, 1, 1, -1);
      8:  return make(C_BIG, C_BIG, -C_BIG, -C_BIG, C_BIG, C_BIG, -C_BIG, C_BIG);
      9:  return make(0, -C_BIG, 0, C_BIG, C_BIG, 1, -C_BIG, 1);
      10: return make(C_BIG, 0, C_BIG, C_BIG, C_BIG, 1, C_BIG, -1);
      11: return make(C_MIN, -1, C_MIN, 1, 0, 1, 0, -1);
      12: return make(1, C_MIN, -1, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX);
      13: return make(-5, 3, 7, -2, 3, 9, -8, -8);
      14: return make(C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN);
      default: return make(C_BIG, 1, C_BIG, -1, -C_BIG, 0, C_BIG, 0);
    endcase
  endfunction

  task automatic send_word(input word_t w);
    int i;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (i = 0; i < 8; i++) drive_c[i] <= w[i];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [TOL_W-1:0] value);
    hold_until_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    #400000;
    $display("timeout with %0d result words still due", pending);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int seg;
    int n;
    int count;
    for (n = 0; n < 8; n++) drive_c[n] <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        send_idle = 19;
        recv_idle = 63;
      end else if (seg < 4) begin
        send_idle = 63;
        recv_idle = 19;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (seg)
        0: set_tolerance(10'd0);
        1: set_tolerance(10'd1023);
        2: set_tolerance(TOL_W'($urandom_range(2, 1022)));
        3: set_tolerance(10'd1);
        4: set_tolerance(TOL_W'($urandom_range(0, 64)));
        default: set_tolerance(TOL_W'($urandom_range(0, 1023)));
      endcase
      if (seg == 0) begin
        for (n = 0; n < 16; n++) send_word(directed_word(n));
      end
      count = (seg < 4) ? 140 : 145;
      for (n = 0; n < count; n++) begin
        if (n == count / 2) hold_until_drained();
        send_word(random_word());
      end
    end
    hold_until_drained();
    repeat (10) @(posedge clk);
    $display("checked %0d result words (%0d crossings) across %0d tolerance settings",
             words_checked, crossings_seen, settings_used);
    $display("idle mixes: sender-heavy, receiver-heavy and none, with full drains between");
    if (miscompares == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d miscompares, %0d result words never arrived", miscompares, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: tangent_crossing_test.f
+incdir+rtl/core
rtl/core/tct_pkg.sv
rtl/core/tct_prerot.sv
rtl/core/tct_cordic_stage.sv
rtl/core/tct_arc_test.sv
rtl/core/tangent_crossing_test.sv
dv/tangent_crossing_checker.sv
dv/testbench.sv
